>>> hw/rtl/svbe_pkg.sv
// ----------------------------------------------------------------------------
// svbe_pkg
// Types and constants shared by the signed variable-length long encoder.
// ----------------------------------------------------------------------------
package svbe_pkg;

    localparam int VAL_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int NBYTES  = VAL_W / BYTE_W;
    localparam int THERM_W = NBYTES - 1;
    localparam int CNT_W   = 4;     // holds 0..8 payload bytes and len 1..8
    localparam int IDX_W   = 3;     // byte index 0..7

    // short-form windows and header offsets
    localparam logic signed [BYTE_W-1:0] FB1_LO  = -8'sd20;
    localparam logic signed [BYTE_W-1:0] FB1_HI  = 8'sd20;
    localparam logic        [BYTE_W-1:0] FB1_OFS = 8'd52;
    localparam logic signed [BYTE_W-1:0] FB2_LO  = -8'sd16;
    localparam logic signed [BYTE_W-1:0] FB2_HI  = 8'sd16;
    localparam logic        [BYTE_W-1:0] FB2_OFS = 8'd88;
    localparam logic signed [BYTE_W-1:0] FB3_LO  = -8'sd8;
    localparam logic signed [BYTE_W-1:0] FB3_HI  = 8'sd8;
    localparam logic        [BYTE_W-1:0] FB3_OFS = 8'd112;
    // len - 129 taken modulo 256
    localparam logic        [BYTE_W-1:0] LONG_BIAS = 8'd127;
    localparam logic        [CNT_W-1:0]  PAY_ONE   = 4'd1;
    localparam logic        [CNT_W-1:0]  PAY_TWO   = 4'd2;
    localparam logic        [CNT_W-1:0]  PAY_THREE = 4'd3;
    localparam logic        [CNT_W-1:0]  PAY_FOUR  = 4'd4;
    localparam logic        [CNT_W-1:0]  PAY_NONE  = 4'd0;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [THERM_W-1:0] therm;   // bit k-1 set when bit length >= 8k
        logic               one_byte;   // value in -32..127
    } t_scan;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [BYTE_W-1:0] header;
        logic [CNT_W-1:0]  npay;
    } t_form;

endpackage

>>> hw/rtl/svbe_if.sv
// ----------------------------------------------------------------------------
// svbe_in_if / svbe_out_if
// Valid/ready channels for values in and encoded bytes out.
// ----------------------------------------------------------------------------
interface svbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface svbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> hw/rtl/svbe_scan.sv
// ----------------------------------------------------------------------------
// svbe_scan
// First stage: byte-length thermometer of the magnitude and small-range test.
// ----------------------------------------------------------------------------
module svbe_scan
    import svbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output t_scan            o_scan
);

    logic               r_valid;
    t_scan              r_scan;
    t_scan              n_scan;
    logic [VAL_W-1:0]   w_mag;
    logic               w_neg;

    assign w_neg = i_value[VAL_W-1];
    assign w_mag = w_neg ? ~i_value : i_value;

    always_comb begin
        n_scan.value = i_value;
        for (int k = 1; k <= THERM_W; k++) begin
            n_scan.therm[k-1] = |(w_mag >> (BYTE_W * k - 1));
        end
        // negative side goes down to -32, positive up to 127
        n_scan.one_byte = w_neg ? (w_mag[VAL_W-1:5] == '0) : (i_value[VAL_W-1:7] == '0);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_scan  = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_scan <= n_scan;
        end
    end

endmodule

>>> hw/rtl/svbe_form.sv
// ----------------------------------------------------------------------------
// svbe_form
// Second stage: picks the encoding form, builds the header and payload count.
// ----------------------------------------------------------------------------
module svbe_form
    import svbe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_scan i_scan,
    output logic  o_valid,
    input  logic  i_ready,
    output t_form o_form
);

    logic                     r_valid;
    t_form                    r_form;
    t_form                    n_form;
    logic [CNT_W-1:0]         w_len;
    logic signed [BYTE_W-1:0] w_b1;
    logic signed [BYTE_W-1:0] w_b2;
    logic signed [BYTE_W-1:0] w_b3;
    logic                     w_c1;
    logic                     w_c2;
    logic                     w_c3;

    always_comb begin
        w_len = PAY_ONE;
        for (int k = 0; k < THERM_W; k++) begin
            w_len = w_len + CNT_W'(i_scan.therm[k]);
        end
    end

    // once len is bounded the shifted value fits in one signed byte
    assign w_b1 = $signed(i_scan.value[2*BYTE_W-1:BYTE_W]);
    assign w_b2 = $signed(i_scan.value[3*BYTE_W-1:2*BYTE_W]);
    assign w_b3 = $signed(i_scan.value[4*BYTE_W-1:3*BYTE_W]);

    assign w_c1 = !i_scan.therm[1] && (w_b1 >= FB1_LO) && (w_b1 < FB1_HI);
    assign w_c2 = !i_scan.therm[2] && (w_b2 >= FB2_LO) && (w_b2 < FB2_HI);
    assign w_c3 = !i_scan.therm[3] && (w_b3 >= FB3_LO) && (w_b3 < FB3_HI);

    always_comb begin
        n_form.value = i_scan.value;
        priority if (i_scan.one_byte) begin
            n_form.header = i_scan.value[BYTE_W-1:0];
            n_form.npay   = PAY_NONE;
        end else if (i_scan.therm[3]) begin
            n_form.header = BYTE_W'(w_len) + LONG_BIAS;
            n_form.npay   = w_len;
        end else if (w_c1) begin
            n_form.header = w_b1 - FB1_OFS;
            n_form.npay   = PAY_ONE;
        end else if (w_c2) begin
            n_form.header = w_b2 - FB2_OFS;
            n_form.npay   = PAY_TWO;
        end else if (w_c3) begin
            n_form.header = w_b3 - FB3_OFS;
            n_form.npay   = PAY_THREE;
        end else begin
            n_form.header = BYTE_W'(w_len) + LONG_BIAS;
            n_form.npay   = PAY_FOUR;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_form  = r_form;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_form <= n_form;
        end
    end

endmodule

>>> hw/rtl/svbe_ser.sv
// ----------------------------------------------------------------------------
// svbe_ser
// Output stage: sends the header and then the payload bytes, high byte first.
// ----------------------------------------------------------------------------
module svbe_ser
    import svbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_form             i_form,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    logic               r_valid;
    logic               r_hdr_ph;
    logic [CNT_W-1:0]   r_rem;
    logic [BYTE_W-1:0]  r_header;
    logic [VAL_W-1:0]   r_value;
    logic [IDX_W-1:0]   w_idx;
    logic               w_fire;
    logic               w_done;

    assign w_idx  = IDX_W'(r_rem - PAY_ONE);
    assign o_byte = r_hdr_ph ? r_header : r_value[w_idx*BYTE_W +: BYTE_W];
    assign o_last = r_hdr_ph ? (r_rem == PAY_NONE) : (r_rem == PAY_ONE);
    assign o_valid = r_valid;

    assign w_fire  = r_valid && i_ready;
    assign w_done  = w_fire && o_last;
    // next item loads in the cycle its predecessor's last byte leaves
    assign o_ready = !r_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hdr_ph <= 1'b0;
            r_rem    <= PAY_NONE;
        end else if (o_ready && i_valid) begin
            r_valid  <= 1'b1;
            r_hdr_ph <= 1'b1;
            r_rem    <= i_form.npay;
        end else if (w_done) begin
            r_valid  <= 1'b0;
        end else if (w_fire) begin
            if (r_hdr_ph) begin
                r_hdr_ph <= 1'b0;
            end else begin
                r_rem <= r_rem - PAY_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_header <= i_form.header;
            r_value  <= i_form.value;
        end
    end

endmodule

>>> hw/rtl/signed_vlong_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// signed_vlong_byte_encoder_top
// Encodes signed 64-bit values into variable-length byte runs.
// ----------------------------------------------------------------------------
// Each value taken on i_in leaves o_out as 1 to 9 bytes, header first, with
// last set on the final byte. Values pass three register stages (length scan,
// form select, byte serializer) before the first byte is offered. The byte-wide
// serializer sets the rate: it holds a value until its header and payload bytes
// have been taken, one byte for values in -32..127 and up to 9 for full-width
// values, and loads the next value in the cycle its last byte is taken.
module signed_vlong_byte_encoder_top
    import svbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    svbe_in_if.sink    i_in,
    svbe_out_if.source o_out
);

    logic  w_scan_valid;
    logic  w_scan_ready;
    t_scan w_scan;
    logic  w_form_valid;
    logic  w_form_ready;
    t_form w_form;

    svbe_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_value (VAL_W'(i_in.value)),
        .o_valid (w_scan_valid),
        .i_ready (w_scan_ready),
        .o_scan  (w_scan)
    );

    svbe_form u_form (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_scan_valid),
        .o_ready (w_scan_ready),
        .i_scan  (w_scan),
        .o_valid (w_form_valid),
        .i_ready (w_form_ready),
        .o_form  (w_form)
    );

    svbe_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_form_valid),
        .o_ready (w_form_ready),
        .i_form  (w_form),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_byte  (o_out.out_byte),
        .o_last  (o_out.last)
    );

endmodule
